>>> hw/rtl/jfds_pkg.sv
// Shared types, codes and constants for the JPEG frame delimiter and source selector.
// No dependencies; imported by every module of the block.
package jfds_pkg;

  localparam int SOURCES_DEF         = 8;
  localparam int MAX_FRAME_BYTES_DEF = 1048576;
  localparam int AGE_BITS_DEF        = 16;

  localparam int SRC_W   = 3;
  localparam int LEN_W   = 21;
  localparam int MODE_W  = 2;
  localparam int NSRC_W  = 4;
  localparam int TMO_W   = 16;
  localparam int CIDX_W  = 3;

  localparam logic [7:0] MARK_BYTE = 8'hFF;
  localparam logic [7:0] SOI_BYTE  = 8'hD8;
  localparam logic [7:0] EOI_BYTE  = 8'hD9;

  localparam logic [NSRC_W-1:0] NSRC_RST    = 4'd2;
  localparam logic [TMO_W-1:0]  TIMEOUT_RST = 16'd500;

  typedef enum logic [1:0] {
    KIND_BYTE = 2'd0,
    KIND_TICK = 2'd1,
    KIND_REQ  = 2'd2
  } kind_e;

  typedef enum logic [MODE_W-1:0] {
    MODE_HIGHEST = 2'd0,
    MODE_SELECT  = 2'd1,
    MODE_CARD    = 2'd2
  } mode_e;

  typedef enum logic [CIDX_W-1:0] {
    CFG_MODE     = 3'd0,
    CFG_SELECT   = 3'd1,
    CFG_NSRC     = 3'd2,
    CFG_TIMEOUT  = 3'd3,
    CFG_TESTCARD = 3'd4
  } cfg_idx_e;

  typedef enum logic [2:0] {
    EV_NONE     = 3'd0,
    EV_DONE     = 3'd1,
    EV_SOURCE   = 3'd2,
    EV_TESTCARD = 3'd3,
    EV_EMPTY    = 3'd4
  } event_e;

  typedef struct packed {
    event_e             ev;
    logic [SRC_W-1:0]   src;
    logic [LEN_W-1:0]   len;
  } result_t;

endpackage

>>> hw/rtl/jfds_lane.sv
// Per-source frame delimiter: marker tracking, length scan, last frame and age.
// Depends on jfds_pkg.
module jfds_lane import jfds_pkg::*; #(
  parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF,
  parameter int AGE_BITS        = AGE_BITS_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   byte_en_i,
  input  logic                                   tick_en_i,
  input  logic [7:0]                             data_byte_i,
  input  logic [TMO_W-1:0]                       timeout_i,
  output logic                                   done_o,
  output logic [$clog2(MAX_FRAME_BYTES+2)-1:0]   done_len_o,
  output logic                                   fresh_o,
  output logic [$clog2(MAX_FRAME_BYTES+2)-1:0]   len_o
);

  localparam int LenW = $clog2(MAX_FRAME_BYTES + 2);
  localparam int CmpW = (AGE_BITS > TMO_W) ? AGE_BITS : TMO_W;
  localparam logic [LenW-1:0] MaxLen = LenW'(MAX_FRAME_BYTES);

  logic                prev_q, prev_d;
  logic                inside_q, inside_d;
  logic                has_q, has_d;
  logic [LenW-1:0]     scan_q, scan_d, scan_inc;
  logic [LenW-1:0]     len_q, len_d;
  logic [AGE_BITS-1:0] age_q, age_d;

  always_comb begin
    prev_d   = prev_q;
    inside_d = inside_q;
    scan_d   = scan_q;
    has_d    = has_q;
    len_d    = len_q;
    age_d    = age_q;
    done_o   = 1'b0;
    // length stops one past the limit so an overlong frame stays marked
    scan_inc = (scan_q <= MaxLen) ? scan_q + LenW'(1) : scan_q;
    if (byte_en_i) begin
      prev_d = (data_byte_i == MARK_BYTE);
      if (!inside_q) begin
        if (prev_q && data_byte_i == SOI_BYTE) begin
          inside_d = 1'b1;
          scan_d   = LenW'(2);
          prev_d   = 1'b0;
        end
      end else begin
        scan_d = scan_inc;
        if (prev_q && data_byte_i == EOI_BYTE) begin
          inside_d = 1'b0;
          prev_d   = 1'b0;
          scan_d   = '0;
          if (scan_inc <= MaxLen) begin
            has_d  = 1'b1;
            len_d  = scan_inc;
            age_d  = '0;
            done_o = 1'b1;
          end
        end
      end
    end else if (tick_en_i && !(&age_q)) begin
      age_d = age_q + AGE_BITS'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q   <= 1'b0;
      inside_q <= 1'b0;
      has_q    <= 1'b0;
      scan_q   <= '0;
      len_q    <= '0;
      age_q    <= '0;
    end else begin
      prev_q   <= prev_d;
      inside_q <= inside_d;
      has_q    <= has_d;
      scan_q   <= scan_d;
      len_q    <= len_d;
      age_q    <= age_d;
    end
  end

  assign done_len_o = scan_inc;
  assign len_o      = len_q;
  assign fresh_o    = has_q && (CmpW'(age_q) < CmpW'(timeout_i));

endmodule

>>> hw/rtl/jfds_select.sv
// Result builder: frame-done reporting and request arbitration across sources.
// Depends on jfds_pkg.
module jfds_select import jfds_pkg::*; #(
  parameter int SOURCES = SOURCES_DEF,
  parameter int LenW    = $clog2(MAX_FRAME_BYTES_DEF + 2)
) (
  input  kind_e                           kind_i,
  input  logic [MODE_W-1:0]               mode_i,
  input  logic [SRC_W-1:0]                sel_i,
  input  logic [$clog2(SOURCES+1)-1:0]    nact_i,
  input  logic [LEN_W-1:0]                testcard_i,
  input  logic [SOURCES-1:0]              fresh_i,
  input  logic [SOURCES-1:0]              done_i,
  input  logic [LenW-1:0]                 len_i [SOURCES],
  input  logic [LenW-1:0]                 done_len_i [SOURCES],
  output result_t                         result_o
);

  localparam int NactW = $clog2(SOURCES + 1);
  localparam int SrcW  = (SOURCES > 1) ? $clog2(SOURCES) : 1;
  localparam int CW    = (NactW > SRC_W) ? NactW : SRC_W;

  logic            found, dn_any, sel_ok, use_sel, use_auto, picked;
  logic [SrcW-1:0] pick_idx, dn_idx, sel_idx, out_idx;

  always_comb begin
    found    = 1'b0;
    pick_idx = '0;
    dn_any   = 1'b0;
    dn_idx   = '0;
    // ascending scan: the last hit is the highest fresh source
    for (int i = 0; i < SOURCES; i++) begin
      if (fresh_i[i] && (CW'(i) < CW'(nact_i))) begin
        found    = 1'b1;
        pick_idx = SrcW'(i);
      end
      if (done_i[i]) begin
        dn_any = 1'b1;
        dn_idx = SrcW'(i);
      end
    end
  end

  assign sel_idx  = SrcW'(sel_i);
  assign sel_ok   = (mode_i == MODE_SELECT) && (CW'(sel_i) < CW'(nact_i));
  assign use_sel  = sel_ok && fresh_i[sel_idx];
  assign use_auto = !sel_ok && found &&
                    (mode_i == MODE_HIGHEST || mode_i == MODE_SELECT);
  assign picked   = use_sel || use_auto;
  assign out_idx  = use_sel ? sel_idx : pick_idx;

  always_comb begin
    result_o = '{ev: EV_NONE, src: '0, len: '0};
    case (kind_i)
      KIND_BYTE: begin
        if (dn_any) begin
          result_o = '{ev: EV_DONE, src: SRC_W'(dn_idx), len: LEN_W'(done_len_i[dn_idx])};
        end
      end
      KIND_REQ: begin
        if (picked) begin
          result_o = '{ev: EV_SOURCE, src: SRC_W'(out_idx), len: LEN_W'(len_i[out_idx])};
        end else if (testcard_i != '0) begin
          result_o = '{ev: EV_TESTCARD, src: '0, len: testcard_i};
        end else begin
          result_o = '{ev: EV_EMPTY, src: '0, len: '0};
        end
      end
      default: ;
    endcase
  end

endmodule

>>> hw/rtl/jpeg_frame_delimit_source_select.sv
// Top level: config registers, input stage, per-source lanes, result register.
// Depends on jfds_pkg, jfds_lane, jfds_select.
//
// Takes one item per clock, back to back while the output is not stalled: a data
// byte, a millisecond tick or a frame request. Each item passes an input register,
// then one combinational pass that updates the addressed source lane (or all ages
// on a tick) and builds exactly one result, which lands in the output register.
// out_valid_o rises once that result is registered; a stalled output still lets
// one more item into the input register.
// Throughput is one item per cycle while the output is not stalled; the per-source
// lane registers are read, modified and written back in one combinational pass.
// Configuration writes take effect on the next item.
module jpeg_frame_delimit_source_select import jfds_pkg::*; #(
  parameter int SOURCES         = SOURCES_DEF,
  parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF,
  parameter int AGE_BITS        = AGE_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CIDX_W-1:0]  cfg_idx_i,
  input  logic [LEN_W-1:0]   cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         kind_i,
  input  logic [SRC_W-1:0]   source_i,
  input  logic [7:0]         data_byte_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [2:0]         event_res_o,
  output logic [SRC_W-1:0]   chosen_source_o,
  output logic [LEN_W-1:0]   frame_length_o
);

  localparam int LenW  = $clog2(MAX_FRAME_BYTES + 2);
  localparam int NactW = $clog2(SOURCES + 1);
  localparam int SrcW  = (SOURCES > 1) ? $clog2(SOURCES) : 1;
  localparam int CW    = (NactW > SRC_W) ? NactW : SRC_W;

  // configuration
  logic [MODE_W-1:0] mode_q;
  logic [SRC_W-1:0]  sel_q;
  logic [NSRC_W-1:0] nsrc_q;
  logic [TMO_W-1:0]  timeout_q;
  logic [LEN_W-1:0]  testcard_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_HIGHEST;
      sel_q      <= '0;
      nsrc_q     <= NSRC_RST;
      timeout_q  <= TIMEOUT_RST;
      testcard_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MODE:     mode_q     <= cfg_wdata_i[MODE_W-1:0];
        CFG_SELECT:   sel_q      <= cfg_wdata_i[SRC_W-1:0];
        CFG_NSRC:     nsrc_q     <= cfg_wdata_i[NSRC_W-1:0];
        CFG_TIMEOUT:  timeout_q  <= cfg_wdata_i[TMO_W-1:0];
        CFG_TESTCARD: testcard_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  logic [NactW-1:0] nact;
  always_comb begin
    if (nsrc_q == '0) begin
      nact = NactW'(1);
    end else if (int'(nsrc_q) > SOURCES) begin
      nact = NactW'(SOURCES);
    end else begin
      nact = NactW'(nsrc_q);
    end
  end

  // input stage
  logic             s1_valid_q;
  kind_e            s1_kind_q;
  logic [SRC_W-1:0] s1_source_q;
  logic [7:0]       s1_byte_q;
  logic             advance, fire;

  assign advance    = !out_valid_o || out_ready_i;
  assign fire       = s1_valid_q && advance;
  assign in_ready_o = !s1_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_kind_q   <= kind_e'(kind_i);
      s1_source_q <= source_i;
      s1_byte_q   <= data_byte_i;
    end
  end

  // source lanes
  logic [SrcW-1:0]    src_idx;
  logic               byte_fire, tick_fire;
  logic [SOURCES-1:0] fresh, done;
  logic [LenW-1:0]    len_arr [SOURCES];
  logic [LenW-1:0]    done_len_arr [SOURCES];

  assign src_idx   = SrcW'(s1_source_q);
  assign byte_fire = fire && (s1_kind_q == KIND_BYTE) && (CW'(s1_source_q) < CW'(nact));
  assign tick_fire = fire && (s1_kind_q == KIND_TICK);

  for (genvar g = 0; g < SOURCES; g++) begin : g_lane
    jfds_lane #(
      .MAX_FRAME_BYTES(MAX_FRAME_BYTES),
      .AGE_BITS       (AGE_BITS)
    ) u_lane (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .byte_en_i  (byte_fire && (src_idx == SrcW'(g))),
      .tick_en_i  (tick_fire),
      .data_byte_i(s1_byte_q),
      .timeout_i  (timeout_q),
      .done_o     (done[g]),
      .done_len_o (done_len_arr[g]),
      .fresh_o    (fresh[g]),
      .len_o      (len_arr[g])
    );
  end

  result_t result, result_q;

  jfds_select #(
    .SOURCES(SOURCES),
    .LenW   (LenW)
  ) u_select (
    .kind_i     (s1_kind_q),
    .mode_i     (mode_q),
    .sel_i      (sel_q),
    .nact_i     (nact),
    .testcard_i (testcard_q),
    .fresh_i    (fresh),
    .done_i     (done),
    .len_i      (len_arr),
    .done_len_i (done_len_arr),
    .result_o   (result)
  );

  // result register
  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      result_q <= result;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign event_res_o     = result_q.ev;
  assign chosen_source_o = result_q.src;
  assign frame_length_o  = result_q.len;

  // assertions
  a_one_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(done))
    else $error("more than one lane closed a frame in one cycle");

  a_none_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && event_res_o == EV_NONE |-> chosen_source_o == '0 && frame_length_o == '0)
    else $error("empty result carries data");

  a_src_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (event_res_o == EV_SOURCE || event_res_o == EV_DONE)
      |-> CW'(chosen_source_o) < CW'(nact))
    else $error("result names an inactive source");

  a_stall_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !advance |=> $stable(s1_byte_q) && $stable(s1_source_q))
    else $error("held item overwritten while output stalled");

endmodule
